### rtl/ct3sf_pkg.sv
`timescale 1ns / 1ps

package ct3sf_pkg;

  // Gray pixel and census code widths are fixed by the stream format.
  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CODE_W-1:0] code_t;

  // One column of the 3x3 window, index 0 is the top row.
  typedef pix_t win_col_t [3];

endpackage

### rtl/census_transform_3x3_split_frame_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word contents
// in_       input      in_valid / in_stall   pixel, frame_start, line_end
// out_      output     out_valid / out_stall census_code, frame_start_out, line_end_out
//
// One word is accepted per clock while in_stall is low; it passes through the
// middle stage registers and then into the output register.
// The throughput is set by the line-store memories, which are read once and
// written once per pixel through a single read port and a single write port.
// After rst_n is released the line stores are swept to zero, one entry per
// cycle, from address 0 to LINE_WIDTH-1; in_stall stays high during that sweep.
// A stall on the output holds the result register and, once the middle
// stage is also full, raises in_stall in the same cycle.
module census_transform_3x3_split_frame_unit
  import ct3sf_pkg::*;
#(
  parameter int LINE_WIDTH = 1280,
  parameter int HALF_LINE  = 640,
  parameter int BORDER     = 2
) (
  input  logic  clk,
  input  logic  rst_n,

  input  logic  in_valid,
  output logic  in_stall,
  input  pix_t  in_pixel,
  input  logic  in_frame_start,
  input  logic  in_line_end,

  output logic  out_valid,
  input  logic  out_stall,
  output code_t out_census_code,
  output logic  out_frame_start_out,
  output logic  out_line_end_out
);

  // The column counter must be able to hold HALF_LINE for the seam compare,
  // so it gets one value more than the line store address needs.
  localparam int COL_W  = $clog2(LINE_WIDTH + 1);
  localparam int ADDR_W = $clog2(LINE_WIDTH);
  localparam int ROW_W  = (BORDER < 2) ? 1 : $clog2(BORDER + 1);

  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(LINE_WIDTH - 1);
  localparam logic [COL_W-1:0]  COL_HALF   = COL_W'(HALF_LINE);
  localparam logic [COL_W-1:0]  COL_BORDER = COL_W'(BORDER);
  localparam logic [COL_W-1:0]  COL_RIGHT  = COL_W'(HALF_LINE - BORDER);
  localparam logic [ROW_W-1:0]  ROW_BORDER = ROW_W'(BORDER);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(LINE_WIDTH - 1);

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The line stores come out of reset through a zeroing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing_r) begin
        if (clr_addr_r == ADDR_LAST) begin
          clearing_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: position counters, border and seam decisions
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt, col_use, col_local;
  logic [ROW_W-1:0] row_r, row_nxt, row_use;
  logic             seam_clr, border_hit;

  always_comb begin
    col_use   = in_frame_start ? '0 : col_r;
    row_use   = in_frame_start ? '0 : row_r;
    // The window is emptied at the start of a frame and where the right
    // half-image begins, so no pixels leak across the seam.
    seam_clr  = in_frame_start || (col_r == COL_HALF);
    col_local = (col_use >= COL_HALF) ? (col_use - COL_HALF) : col_use;
    border_hit = (col_local < COL_BORDER) || (col_local >= COL_RIGHT) ||
                 (row_use < ROW_BORDER);

    row_nxt = row_use;
    if (in_line_end) begin
      col_nxt = '0;
      if (row_use < ROW_BORDER) begin
        row_nxt = row_use + ROW_W'(1);
      end
    end else if (col_use < COL_LAST) begin
      col_nxt = col_use + COL_W'(1);
    end else begin
      // An over-long row keeps reusing the last line-store entry.
      col_nxt = col_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: read at accept, written when the middle stage advances
  // ---------------------------------------------------------------------
  pix_t upper_mem [LINE_WIDTH];
  pix_t middle_mem [LINE_WIDTH];
  pix_t upper_rd_r, middle_rd_r;

  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  pix_t              wr_upper, wr_middle;

  // Middle stage registers
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_pix_r;
  logic             s1_fs_r, s1_le_r, s1_clr_r, s1_border_r;
  logic             s1_fwd_r;
  pix_t             fwd_upper_r, fwd_middle_r;
  pix_t             above2, above1;

  assign rd_addr = col_use[ADDR_W-1:0];

  // The previous pixel writes its column on the same edge at which the
  // next one reads; when the columns match the new values are forwarded.
  assign above2 = s1_fwd_r ? fwd_upper_r  : upper_rd_r;
  assign above1 = s1_fwd_r ? fwd_middle_r : middle_rd_r;

  assign wr_en     = clearing_r || s1_adv;
  assign wr_addr   = clearing_r ? clr_addr_r : s1_col_r[ADDR_W-1:0];
  assign wr_upper  = clearing_r ? '0 : above1;
  assign wr_middle = clearing_r ? '0 : s1_pix_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
    end
    if (in_acc) begin
      upper_rd_r <= upper_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_mem[wr_addr] <= wr_middle;
    end
    if (in_acc) begin
      middle_rd_r <= middle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r     <= col_use;
      s1_pix_r     <= in_pixel;
      s1_fs_r      <= in_frame_start;
      s1_le_r      <= in_line_end;
      s1_clr_r     <= seam_clr;
      s1_border_r  <= border_hit;
      s1_fwd_r     <= s1_valid_r && (s1_col_r == col_use);
      fwd_upper_r  <= above1;
      fwd_middle_r <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------
  // Window shift and census compare
  // ---------------------------------------------------------------------
  win_col_t win_r [3];
  win_col_t win_nxt [3];
  code_t    code;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[0][r] = s1_clr_r ? '0 : win_r[1][r];
      win_nxt[1][r] = s1_clr_r ? '0 : win_r[2][r];
    end
    win_nxt[2][0] = above2;
    win_nxt[2][1] = above1;
    win_nxt[2][2] = s1_pix_r;

    // Bits run over the top row, the middle row without its centre, and
    // the bottom row, each from left to right.
    code[0] = win_nxt[0][0] >= win_nxt[1][1];
    code[1] = win_nxt[1][0] >= win_nxt[1][1];
    code[2] = win_nxt[2][0] >= win_nxt[1][1];
    code[3] = win_nxt[0][1] >= win_nxt[1][1];
    code[4] = win_nxt[2][1] >= win_nxt[1][1];
    code[5] = win_nxt[0][2] >= win_nxt[1][1];
    code[6] = win_nxt[1][2] >= win_nxt[1][1];
    code[7] = win_nxt[2][2] >= win_nxt[1][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < 3; q++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[q][r] <= '0;
        end
      end
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  code_t out_code_r;
  logic  out_fs_r, out_le_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_code_r <= s1_border_r ? '0 : code;
      out_fs_r   <= s1_fs_r;
      out_le_r   <= s1_le_r;
    end
  end

  assign out_census_code     = out_code_r;
  assign out_frame_start_out = out_fs_r;
  assign out_line_end_out    = out_le_r;

endmodule

### rtl/ct3sf_checker.sv
`timescale 1ns / 1ps

module ct3sf_checker
  import ct3sf_pkg::*;
#(
  parameter int BORDER = 2
) (
  input logic  clk,
  input logic  rst_n,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input code_t out_census_code,
  input logic  out_frame_start_out
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // The line stores are being swept right after reset, so no word enters.
  a_sweep_stall: assert property (@(posedge clk) $rose(rst_n) |-> in_stall)
    else $error("input word could be taken during the line-store sweep");

  // A stalled word holds its code.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_census_code))
    else $error("stalled output word changed");

  // The first pixel of a frame lies in the top border rows.
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (BORDER > 0) && out_valid && out_frame_start_out |->
      out_census_code == code_t'(0))
    else $error("nonzero code on the first pixel of a frame");

endmodule

bind census_transform_3x3_split_frame_unit ct3sf_checker #(
  .BORDER(BORDER)
) u_ct3sf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_census_code    (out_census_code),
  .out_frame_start_out(out_frame_start_out)
);

### verif/census_transform_3x3_split_frame_unit_test.sv
`timescale 1ns / 1ps

module census_transform_3x3_split_frame_unit_test;
  import ct3sf_pkg::*;

  localparam int LINE_WIDTH = 1280;
  localparam int HALF_LINE  = 640;
  localparam int BORDER     = 2;

  // Short rows make up the random frames; one long row crosses the half
  // seam and runs past the end of the line store.
  localparam int SHORT_WORDS = 280;

  // The slowest correct run is the line-store sweep plus about 1700 words,
  // each paying a sender gap and a receiver stall, plus two long hold-offs.
  // This limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 100000;

  localparam int HOLD_CYCLES = 90;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  pix_t  in_pixel = '0;
  logic  in_frame_start = 1'b0;
  logic  in_line_end = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  code_t out_census_code;
  logic  out_frame_start_out;
  logic  out_line_end_out;

  census_transform_3x3_split_frame_unit #(
    .LINE_WIDTH(LINE_WIDTH),
    .HALF_LINE (HALF_LINE),
    .BORDER    (BORDER)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel           (in_pixel),
    .in_frame_start     (in_frame_start),
    .in_line_end        (in_line_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_census_code    (out_census_code),
    .out_frame_start_out(out_frame_start_out),
    .out_line_end_out   (out_line_end_out)
  );

  always #10 clk = ~clk;

  // One expected output word: the census byte and the two passed marks.
  typedef struct {
    code_t code;
    logic  fs;
    logic  le;
  } census_word_t;

  // One row of the directed table. Where known is set, code is the value
  // that the output must carry; otherwise the census model supplies it.
  typedef struct packed {
    pix_t  px;
    logic  fs;
    logic  le;
    logic  known;
    code_t code;
  } stim_row_t;

  census_word_t codes_due [$];
  census_word_t due_w;

  // Census model state.
  pix_t        upper_mem  [LINE_WIDTH];
  pix_t        middle_mem [LINE_WIDTH];
  pix_t        win [3][3];
  logic [10:0] col_cnt = '0;
  logic [1:0]  row_cnt = '0;

  int mismatches     = 0;
  int results_checked = 0;
  int words_sent     = 0;
  int short_items    = 0;
  int frames         = 0;
  int seam_rows      = 0;
  int overlong_rows  = 0;
  int words_seen     = 0;
  int hold_left      = 0;
  int cycle_cnt      = 0;

  initial begin
    for (int i = 0; i < LINE_WIDTH; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int q = 0; q < 3; q++)
        win[r][q] = '0;
  end

  task automatic note_mismatch(string what, int got, int want);
    $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h",
             results_checked, what, got, want);
    mismatches++;
  endtask

  // Census code of one pixel, advancing the model's line stores, window and
  // counters exactly as the block does.
  function automatic code_t census_predict(pix_t px, logic fs, logic le);
    logic [10:0] col;
    logic [10:0] half_col;
    pix_t        above2;
    pix_t        above1;
    pix_t        ctr;
    code_t       code;
    int          k;
    code = '0;
    // The window starts empty at a frame start and at the half seam.
    if (fs || col_cnt == 11'(HALF_LINE)) begin
      for (int r = 0; r < 3; r++)
        for (int q = 0; q < 3; q++)
          win[r][q] = '0;
    end
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    col = (col_cnt >= 11'(LINE_WIDTH)) ? 11'(LINE_WIDTH - 1) : col_cnt;
    above2 = upper_mem[col];
    above1 = middle_mem[col];
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = px;
    upper_mem[col]  = above1;
    middle_mem[col] = px;
    ctr = win[1][1];
    k = 0;
    for (int r = 0; r < 3; r++) begin
      for (int q = 0; q < 3; q++) begin
        if (!(r == 1 && q == 1)) begin
          if (win[r][q] >= ctr)
            code[k] = 1'b1;
          k++;
        end
      end
    end
    half_col = (col < 11'(HALF_LINE)) ? col : col - 11'(HALF_LINE);
    if (half_col < 11'(BORDER) || half_col >= 11'(HALF_LINE - BORDER) ||
        row_cnt < 2'(BORDER))
      code = '0;
    if (le) begin
      col_cnt = '0;
      if (row_cnt < 2'(BORDER))
        row_cnt = row_cnt + 2'd1;
    end else if (col < 11'(LINE_WIDTH - 1)) begin
      col_cnt = col + 11'd1;
    end else begin
      col_cnt = col;
    end
    return code;
  endfunction

  // Half full-range values, a quarter extremes and a quarter a narrow band around
  // mid-gray so that equal neighbors show up often.
  function automatic pix_t pick_pixel();
    case ($urandom_range(3))
      0: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      1: return pix_t'($urandom_range(130, 126));
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  // Offers one word, idling first now and then, and holds it until the
  // block takes it. The expected output is queued at acceptance.
  task automatic send_word(pix_t px, logic fs, logic le, logic known, code_t want);
    census_word_t w;
    bit calm;
    calm = (words_sent >= 600 && words_sent < 900);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= fs;
    in_line_end    <= le;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    w.code = census_predict(px, fs, le);
    if (known)
      w.code = want;
    w.fs = fs;
    w.le = le;
    codes_due.push_back(w);
    words_sent++;
  endtask

  // One raster row. Short rows carry occasional flipped marks as noise.
  task automatic send_row(int len, bit mark_start, bit mark_end, bit is_short);
    logic fs;
    logic le;
    for (int i = 0; i < len; i++) begin
      fs = mark_start && (i == 0);
      le = mark_end && (i == len - 1);
      if (is_short && $urandom_range(99) < 4)
        fs = ~fs;
      if (is_short && $urandom_range(99) < 4)
        le = ~le;
      send_word(pick_pixel(), fs, le, 1'b0, '0);
      if (is_short)
        short_items++;
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (codes_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, a calm stretch, and two long hold-offs that
  // start when its own count of accepted input words reaches a mark.
  always @(posedge clk) begin
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      if (words_seen == 399 || words_seen == 1199)
        hold_left = HOLD_CYCLES;
      words_seen++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (words_seen >= 600 && words_seen < 900) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 19);
    end
  end

  // Each output word taken is matched against the oldest pending word.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (codes_due.size() == 0) begin
        note_mismatch("output word with none pending", int'(out_census_code), 0);
      end else begin
        due_w = codes_due.pop_front();
        if (out_census_code !== due_w.code)
          note_mismatch("census_code", int'(out_census_code), int'(due_w.code));
        if (out_frame_start_out !== due_w.fs)
          note_mismatch("frame_start_out", int'(out_frame_start_out), int'(due_w.fs));
        if (out_line_end_out !== due_w.le)
          note_mismatch("line_end_out", int'(out_line_end_out), int'(due_w.le));
        results_checked++;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d words still pending",
             cycle_cnt, codes_due.size());
    $display("census_transform_3x3_split_frame_unit verification failed");
    $finish;
  end

  initial begin
    stim_row_t dir_tab [24];
    int  frame_rows;
    bit  drained_once;
    drained_once = 1'b0;
    // The first two rows of a frame are always border, as are the first two
    // columns of every row; those entries carry a typed zero.
    dir_tab = '{
      '{8'd255, 1'b1, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd255, 1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd128, 1'b0, 1'b1, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd255, 1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd255, 1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd128, 1'b0, 1'b1, 1'b1, 8'd0},
      '{8'd255, 1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd255, 1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
      '{8'd7,   1'b0, 1'b1, 1'b0, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
      '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
      '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0},
      '{8'd200, 1'b0, 1'b0, 1'b1, 8'd0},
      // Frame start in the middle of a row, then start and end together.
      '{8'd255, 1'b1, 1'b0, 1'b1, 8'd0},
      '{8'd0,   1'b1, 1'b1, 1'b1, 8'd0},
      '{8'd9,   1'b0, 1'b1, 1'b1, 8'd0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++)
      send_word(dir_tab[i].px, dir_tab[i].fs, dir_tab[i].le,
                dir_tab[i].known, dir_tab[i].code);

    // Random frames. Frame two always carries one over-long row, which also
    // crosses the half seam.
    while (short_items < SHORT_WORDS || frames < 3) begin
      frame_rows = $urandom_range(6, 1);
      if (frames == 2)
        frame_rows = 4;
      for (int r = 0; r < frame_rows; r++) begin
        if (frames == 2 && r == 2) begin
          send_row(1300, 1'b0, 1'b1, 1'b0);
          seam_rows++;
          overlong_rows++;
        end else begin
          send_row($urandom_range(24, 1), (r == 0) && ($urandom_range(99) >= 5),
                   $urandom_range(99) >= 5, 1'b1);
        end
      end
      frames++;
      if (!drained_once && frames == 3) begin
        wait_for_drain();
        drained_once = 1'b1;
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d words in %0d random frames plus a directed table;",
             words_sent, frames);
    $display("%0d rows crossed the half seam, %0d ran past the line store, %0d outputs checked.",
             seam_rows, overlong_rows, results_checked);
    if (mismatches == 0) begin
      $display("census_transform_3x3_split_frame_unit verification clean");
    end else begin
      $display("census_transform_3x3_split_frame_unit verification failed");
    end
    $finish;
  end

endmodule
